// ===== src/sei_pkg.sv =====
package sei_pkg;

  localparam int MAX_EXTENTS = 64;
  // one cell per slot that can be held; the last table slot is never used
  localparam int NCELL = MAX_EXTENTS - 1;
  localparam int CNT_W = $clog2(MAX_EXTENTS);

  typedef struct packed {
    logic [31:0] start_sector;
    logic [31:0] extent_length;
  } in_word_t;

  typedef struct packed {
    logic       overlap;
    logic       stored;
    logic       table_full;
    logic [5:0] entry_count;
  } out_word_t;

  typedef struct packed {
    logic cmp;
    logic ins;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_OUT
  } state_t;

endpackage

// ===== src/sei_cell.sv =====
module sei_cell (
  input  logic                clk,
  input  sei_pkg::cell_ctl_t  ctl,
  input  logic [31:0]         new_start,
  input  logic [31:0]         new_len,
  input  logic [32:0]         new_last,
  input  logic                occ,
  input  logic                left_gt,
  input  logic [31:0]         left_start,
  input  logic [31:0]         left_len,
  output logic [31:0]         start_r,
  output logic [31:0]         len_r,
  output logic                gt_r,
  output logic                meets_r
);
  import sei_pkg::*;

  logic [32:0] old_end;
  logic        gt_nxt;
  logic        meets_nxt;

  always_comb begin
    old_end   = {1'b0, start_r} + {1'b0, len_r};
    gt_nxt    = occ && (new_start > start_r);
    meets_nxt = (new_last >= {1'b0, start_r}) && ({1'b0, new_start} < old_end);
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      gt_r    <= gt_nxt;
      meets_r <= meets_nxt;
    end
    // cells at or above the insert point move up; the insert point takes the new extent
    if (ctl.ins && !gt_r) begin
      start_r <= left_gt ? new_start : left_start;
      len_r   <= left_gt ? new_len : left_len;
    end
  end

endmodule

// ===== src/sei_ctrl.sv =====
module sei_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sei_pkg::in_word_t             in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sei_pkg::out_word_t            out_word,
  input  logic [sei_pkg::NCELL-1:0]     gt,
  input  logic [sei_pkg::NCELL-1:0]     meets,
  output logic [sei_pkg::NCELL-1:0]     occ,
  output sei_pkg::cell_ctl_t            ctl,
  output logic [31:0]                   item_start_r,
  output logic [31:0]                   item_len_r,
  output logic [32:0]                   item_last_r
);
  import sei_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  out_word_t        res_r, res_nxt;
  logic             nonzero;
  logic             full;
  logic             ovl;
  logic             prev_hit;
  logic             at_hit;
  logic             right_gt;
  logic             left_gt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_UPD;
      S_UPD:   state_nxt = S_OUT;
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != S_IDLE);
    out_valid = (state_r == S_OUT);
    ctl.cmp   = (state_r == S_CMP);
    ctl.ins   = (state_r == S_UPD) && nonzero && !full;
  end

  always_comb begin
    nonzero = (item_len_r != 32'd0);
    full    = (count_r == CNT_W'(MAX_EXTENTS - 1));
    for (int i = 0; i < NCELL; i++) begin
      occ[i] = (CNT_W'(i) < count_r);
    end
    // only the entry just below the insert point and the one at it are checked
    ovl = 1'b0;
    for (int i = 0; i < NCELL; i++) begin
      right_gt = (i < NCELL - 1) ? gt[(i < NCELL - 1) ? i + 1 : i] : 1'b0;
      left_gt  = (i > 0) ? gt[(i > 0) ? i - 1 : i] : 1'b1;
      prev_hit = gt[i] && !right_gt;
      at_hit   = occ[i] && !gt[i] && left_gt;
      ovl      = ovl || (meets[i] && (prev_hit || at_hit));
    end
    count_nxt = count_r;
    res_nxt   = res_r;
    if (state_r == S_UPD) begin
      if (nonzero && !full) begin
        count_nxt = count_r + CNT_W'(1);
      end
      res_nxt.overlap     = nonzero && ovl;
      res_nxt.stored      = nonzero && !full;
      res_nxt.table_full  = nonzero && full;
      res_nxt.entry_count = 6'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    res_r <= res_nxt;
    if (state_r == S_IDLE && in_valid) begin
      item_start_r <= in_word.start_sector;
      item_len_r   <= in_word.extent_length;
      item_last_r  <= {1'b0, in_word.start_sector} + {1'b0, in_word.extent_length} - 33'd1;
    end
  end

  assign out_word = res_r;

endmodule

// ===== src/sorted_extent_insert_overlap.sv =====
// channel | ports                          | word
// in      | in_valid, in_stall, in_word    | sei_pkg::in_word_t (start_sector, extent_length)
// out     | out_valid, out_stall, out_word | sei_pkg::out_word_t (overlap, stored, ...)
//
// one word at a time: accept, compare in every cell, shift/insert, then the
// result register, which holds the result for as long as out_stall is high.
// in_stall stays high from acceptance until the result is taken.
// rst_n clears the held count and the control state; cell contents are
// don't-care until written.
module sorted_extent_insert_overlap (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sei_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output sei_pkg::out_word_t out_word
);
  import sei_pkg::*;

  cell_ctl_t          ctl;
  logic [NCELL-1:0]   gt;
  logic [NCELL-1:0]   meets;
  logic [NCELL-1:0]   occ;
  logic [31:0]        item_start;
  logic [31:0]        item_len;
  logic [32:0]        item_last;
  logic [31:0]        cell_start [NCELL];
  logic [31:0]        cell_len   [NCELL];

  sei_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .gt           (gt),
    .meets        (meets),
    .occ          (occ),
    .ctl          (ctl),
    .item_start_r (item_start),
    .item_len_r   (item_len),
    .item_last_r  (item_last)
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i == 0) begin : g_first
      sei_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .new_start  (item_start),
        .new_len    (item_len),
        .new_last   (item_last),
        .occ        (occ[i]),
        .left_gt    (1'b1),
        .left_start (item_start),
        .left_len   (item_len),
        .start_r    (cell_start[i]),
        .len_r      (cell_len[i]),
        .gt_r       (gt[i]),
        .meets_r    (meets[i])
      );
    end else begin : g_rest
      sei_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .new_start  (item_start),
        .new_len    (item_len),
        .new_last   (item_last),
        .occ        (occ[i]),
        .left_gt    (gt[i-1]),
        .left_start (cell_start[i-1]),
        .left_len   (cell_len[i-1]),
        .start_r    (cell_start[i]),
        .len_r      (cell_len[i]),
        .gt_r       (gt[i]),
        .meets_r    (meets[i])
      );
    end
  end

endmodule

// ===== src/sei_checker.sv =====
module sei_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input sei_pkg::out_word_t out_word
);
  import sei_pkg::*;

  // one word in flight: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall && !out_valid))
    else $error("input taken while a word is in flight");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled result changed");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.stored && out_word.table_full))
    else $error("stored and table_full both set");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.table_full) |-> (out_word.entry_count == 6'(MAX_EXTENTS - 1)))
    else $error("drop reported below capacity");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> !in_stall)
    else $error("not ready after result taken");

endmodule

bind sorted_extent_insert_overlap sei_checker u_sei_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

// ===== test/tb_top.sv =====
module tb_top;
  import sei_pkg::*;

  localparam int N_RANDOM = 1050;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  class extent_book;
    logic [31:0] starts[MAX_EXTENTS];
    logic [31:0] lens[MAX_EXTENTS];
    int unsigned held;
    out_word_t   due_q[$];
    int          errors;
    int          n_zero, n_stored, n_full, n_overlap;

    function new();
      held = 0;
      errors = 0;
      n_zero = 0;
      n_stored = 0;
      n_full = 0;
      n_overlap = 0;
    endfunction

    // 33-bit sums so an extent near the top never wraps to sector zero
    function bit meets(logic [31:0] s, logic [31:0] len, int unsigned k);
      logic [32:0] new_last;
      logic [32:0] old_end;
      new_last = {1'b0, s} + {1'b0, len} - 33'd1;
      old_end = {1'b0, starts[k]} + {1'b0, lens[k]};
      return (new_last >= {1'b0, starts[k]}) && ({1'b0, s} < old_end);
    endfunction

    function void note_extent(in_word_t w);
      int unsigned pos;
      out_word_t   e;
      pos = 0;
      e = '0;
      if (w.extent_length == 32'd0) begin
        n_zero++;
      end else begin
        // equal starts: new extent goes ahead of the held one
        while (pos < held && w.start_sector > starts[pos]) pos++;
        if (pos > 0 && meets(w.start_sector, w.extent_length, pos - 1)) e.overlap = 1'b1;
        if (pos < held && meets(w.start_sector, w.extent_length, pos)) e.overlap = 1'b1;
        if (held < MAX_EXTENTS - 1) begin
          for (int unsigned j = held; j > pos; j--) begin
            starts[j] = starts[j - 1];
            lens[j] = lens[j - 1];
          end
          starts[pos] = w.start_sector;
          lens[pos] = w.extent_length;
          held++;
          e.stored = 1'b1;
          n_stored++;
        end else begin
          e.table_full = 1'b1;
          n_full++;
        end
        if (e.overlap) n_overlap++;
      end
      e.entry_count = 6'(held);
      due_q.push_back(e);
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned got);
      if (exp != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, got);
        errors++;
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (due_q.size() == 0) begin
        $display("%0t: result word with nothing expected: %p", $time, got);
        errors++;
      end else begin
        e = due_q.pop_front();
        compare_field("overlap", e.overlap, got.overlap);
        compare_field("stored", e.stored, got.stored);
        compare_field("table_full", e.table_full, got.table_full);
        compare_field("entry_count", e.entry_count, got.entry_count);
      end
    endfunction

    function void finish_up();
      if (due_q.size() != 0) begin
        $display("%0t: %0d expected result words never arrived", $time, due_q.size());
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  extent_book book;
  int         n_sent;
  int         n_results;

  sorted_extent_insert_overlap u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // quiet window in the middle of the run: no gaps from either side
  function automatic bit take_gap(int n);
    if (n >= 300 && n < 500) return 1'b0;
    return $urandom_range(0, 99) < 6;
  endfunction

  task automatic claim_extent(input logic [31:0] s, input logic [31:0] len);
    in_word_t w;
    w.start_sector = s;
    w.extent_length = len;
    if (take_gap(n_sent)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_extent(w);
    n_sent++;
  endtask

  function automatic logic [31:0] pick_length();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  task automatic random_extents();
    int          counted;
    int unsigned roll;
    logic [31:0] s;
    logic [31:0] len;
    logic [31:0] anchor;
    counted = 0;
    while (counted < N_RANDOM) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        s = $urandom;
        len = 32'd0;
      end else if (roll < 35) begin
        s = $urandom;
        len = pick_length();
      end else if (roll < 80) begin
        // land close to something already held to hit the neighbor checks
        anchor = (book.held > 0) ? book.starts[$urandom_range(0, book.held - 1)] : $urandom;
        s = anchor + $urandom_range(0, 16) - 32'd8;
        len = $urandom_range(1, 24);
      end else begin
        case ($urandom_range(0, 2))
          0: s = 32'd0;
          1: s = 32'hFFFF_FFFF;
          default: s = 32'hFFFF_FFFF - $urandom_range(0, 31);
        endcase
        len = pick_length();
      end
      claim_extent(s, len);
      if (len != 32'd0) counted++;
    end
  endtask

  initial begin : result_side
    int hold_left;
    bit held_off;
    hold_left = 0;
    held_off = 1'b0;
    n_results = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        book.check_result(out_word);
        n_results++;
      end
      // one long hold-off so the block backs up and stalls its input
      if (hold_left > 0) begin
        hold_left--;
      end else if (!held_off && n_results == 150) begin
        hold_left = HOLD_CYCLES;
        held_off = 1'b1;
      end
      out_stall <= (hold_left > 0) || take_gap(n_results);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    book = new();
    n_sent = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_word <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    claim_extent(32'd0, 32'd0);                       // zero length on empty table
    claim_extent(32'd0, 32'd1);
    claim_extent(32'hFFFF_FFFF, 32'hFFFF_FFFF);       // sum past 32 bits
    claim_extent(32'hFFFF_FFF0, 32'd16);              // touches the top entry
    claim_extent(32'd100, 32'd10);
    claim_extent(32'd110, 32'd5);                     // adjacent, no overlap
    claim_extent(32'd109, 32'd1);                     // overlaps the one before
    claim_extent(32'd100, 32'd3);                     // equal start goes first
    claim_extent(32'd95, 32'd5);                      // ends right where next begins
    claim_extent(32'd95, 32'd6);
    claim_extent(32'd0, 32'hFFFF_FFFF);
    claim_extent(32'h8000_0000, 32'h8000_0000);       // runs exactly to the end
    claim_extent(32'hFFFF_FFFF, 32'd0);
    claim_extent(32'h5555_5555, 32'hAAAA_AAAA);
    claim_extent(32'hAAAA_AAAA, 32'h5555_5555);
    claim_extent(32'd1, 32'd1);

    random_extents();
    in_valid <= 1'b0;

    while (book.due_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    book.finish_up();

    $display("%0d extent words sent, %0d zero-length, %0d stored, %0d dropped on a full table",
             n_sent, book.n_zero, book.n_stored, book.n_full);
    $display("%0d overlaps flagged, %0d result words checked", book.n_overlap, n_results);
    if (book.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
